// ===== rtl/gbci_pkg.sv =====
package gbci_pkg;

    localparam int GATE_W     = 12;
    localparam int LEN_W      = 13;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 29;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int M_TDATA_W  = 64;
    localparam int M_PAD_W    = M_TDATA_W - 2 * OUT_W;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SIG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_FROM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_TO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_FROM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TO       = 3'd5;

    localparam logic [LEN_W-1:0]  RST_RECORD_LENGTH = 13'd1024;
    localparam logic [GATE_W-1:0] RST_BASELINE_FROM = 12'd0;
    localparam logic [GATE_W-1:0] RST_BASELINE_TO   = 12'd100;
    localparam logic [GATE_W-1:0] RST_SIGNAL_FROM   = 12'd150;
    localparam logic [GATE_W-1:0] RST_SIGNAL_TO     = 12'd1000;
    localparam logic [GATE_W-1:0] RST_FAST_TO       = 12'd300;

    typedef enum logic [4:0] {
        ST_ACC = 5'b00001,
        ST_MUL = 5'b00010,
        ST_DIV = 5'b00100,
        ST_SUB = 5'b01000,
        ST_OUT = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/gated_baseline_charge_integrator.sv =====
// Within a record one sample word is accepted every cycle.
// After the last sample of a record the block is not ready while the shared
// one-bit-per-cycle divider runs once per integral; the result word turns valid
// as the block turns ready, and a result still waiting stretches the stall.
// A bad gate skips the division and gives both integrals as zero.
// aresetn is synchronous, active low; it restores the default gates and clears all sums.
module gated_baseline_charge_integrator #(
    parameter int MAX_RECORD  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sample
    input  logic [gbci_pkg::SAMPLE_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: slow_integral, fast_integral, zero padding
    output logic [gbci_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: status
    output logic [gbci_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gbci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbci_pkg::LEN_W-1:0]          cfg_data
);

    localparam int GATE_W = gbci_pkg::GATE_W;
    localparam int LEN_W  = gbci_pkg::LEN_W;
    localparam int OUT_W  = gbci_pkg::OUT_W;
    localparam int IDX_W  = $clog2(MAX_RECORD);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int PROD_W = GATE_W + SUM_W;
    localparam int WIDE_W = (PROD_W > OUT_W) ? PROD_W : OUT_W;
    localparam int CMP_W  = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    logic [LEN_W-1:0]  record_length_reg;
    logic [GATE_W-1:0] baseline_from_reg;
    logic [GATE_W-1:0] baseline_to_reg;
    logic [GATE_W-1:0] signal_from_reg;
    logic [GATE_W-1:0] signal_to_reg;
    logic [GATE_W-1:0] fast_to_reg;

    gbci_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] index_reg;
    logic [SUM_W-1:0] base_sum_reg, sig_sum_reg, fast_sum_reg;
    logic [SUM_W-1:0] base_hold_reg, sig_hold_reg, fast_hold_reg;
    logic             pass_reg;
    logic [OUT_W-1:0] slow_res_reg, fast_res_reg;
    logic [gbci_pkg::STATUS_W-1:0] status_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] out_slow_reg, out_fast_reg;
    logic [gbci_pkg::STATUS_W-1:0] out_status_reg;

    logic [SUM_W-1:0]  sample_ext;
    logic [CMP_W-1:0]  idx_c, len_eff;
    logic              in_base, in_sig, in_fast, last;
    logic [SUM_W-1:0]  base_add, sig_add, fast_add;
    logic              bad_base, bad_sig, bad_fast;
    logic              accept, start;
    logic [GATE_W-1:0] glen, blen;
    logic [PROD_W-1:0] quotient;
    logic [WIDE_W-1:0] diff;
    gbci_pkg::div_stat_t div_stat;

    function automatic logic gate_bad(input logic [GATE_W-1:0] from,
                                      input logic [GATE_W-1:0] to,
                                      input logic [CMP_W-1:0]  len);
        return (from >= to) || (CMP_W'(to) >= len - 1'b1);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_length_reg <= gbci_pkg::RST_RECORD_LENGTH;
            baseline_from_reg <= gbci_pkg::RST_BASELINE_FROM;
            baseline_to_reg   <= gbci_pkg::RST_BASELINE_TO;
            signal_from_reg   <= gbci_pkg::RST_SIGNAL_FROM;
            signal_to_reg     <= gbci_pkg::RST_SIGNAL_TO;
            fast_to_reg       <= gbci_pkg::RST_FAST_TO;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gbci_pkg::CFG_RECORD_LENGTH: record_length_reg <= cfg_data;
                gbci_pkg::CFG_BASELINE_FROM: baseline_from_reg <= cfg_data[GATE_W-1:0];
                gbci_pkg::CFG_BASELINE_TO:   baseline_to_reg   <= cfg_data[GATE_W-1:0];
                gbci_pkg::CFG_SIGNAL_FROM:   signal_from_reg   <= cfg_data[GATE_W-1:0];
                gbci_pkg::CFG_SIGNAL_TO:     signal_to_reg     <= cfg_data[GATE_W-1:0];
                gbci_pkg::CFG_FAST_TO:       fast_to_reg       <= cfg_data[GATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (record_length_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(record_length_reg) > CMP_W'(MAX_RECORD)) begin
            len_eff = CMP_W'(MAX_RECORD);
        end else begin
            len_eff = CMP_W'(record_length_reg);
        end
    end

    assign sample_ext = SUM_W'(s_tdata[SAMPLE_BITS-1:0]);
    assign idx_c      = CMP_W'(index_reg);
    assign in_base    = (idx_c >= CMP_W'(baseline_from_reg)) && (idx_c < CMP_W'(baseline_to_reg));
    assign in_sig     = (idx_c >= CMP_W'(signal_from_reg)) && (idx_c < CMP_W'(signal_to_reg));
    assign in_fast    = (idx_c >= CMP_W'(signal_from_reg)) && (idx_c < CMP_W'(fast_to_reg));
    assign last       = (idx_c + 1'b1) >= len_eff;
    assign base_add   = in_base ? base_sum_reg + sample_ext : base_sum_reg;
    assign sig_add    = in_sig  ? sig_sum_reg  + sample_ext : sig_sum_reg;
    assign fast_add   = in_fast ? fast_sum_reg + sample_ext : fast_sum_reg;

    assign bad_base = gate_bad(baseline_from_reg, baseline_to_reg, len_eff);
    assign bad_sig  = gate_bad(signal_from_reg, signal_to_reg, len_eff);
    assign bad_fast = gate_bad(signal_from_reg, fast_to_reg, len_eff);

    assign s_tready = (state_reg == gbci_pkg::ST_ACC);
    assign accept   = s_tvalid && s_tready;
    assign start    = (state_reg == gbci_pkg::ST_MUL);
    assign blen     = baseline_to_reg - baseline_from_reg;
    assign glen     = pass_reg ? fast_to_reg - signal_from_reg : signal_to_reg - signal_from_reg;
    assign diff     = WIDE_W'(pass_reg ? fast_hold_reg : sig_hold_reg) - WIDE_W'(quotient);

    gbci_div #(
        .DVD_W (PROD_W),
        .DVS_W (GATE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (glen * base_hold_reg),
        .divisor  (blen),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbci_pkg::ST_ACC: begin
                if (accept && last) begin
                    state_next = (bad_base || bad_sig || bad_fast) ? gbci_pkg::ST_OUT
                                                                   : gbci_pkg::ST_MUL;
                end
            end
            gbci_pkg::ST_MUL: state_next = gbci_pkg::ST_DIV;
            gbci_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = gbci_pkg::ST_SUB;
                end
            end
            gbci_pkg::ST_SUB: state_next = pass_reg ? gbci_pkg::ST_OUT : gbci_pkg::ST_MUL;
            gbci_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = gbci_pkg::ST_ACC;
                end
            end
            default: state_next = gbci_pkg::ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbci_pkg::ST_ACC;
            index_reg    <= '0;
            base_sum_reg <= '0;
            sig_sum_reg  <= '0;
            fast_sum_reg <= '0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (last) begin
                    index_reg    <= '0;
                    base_sum_reg <= '0;
                    sig_sum_reg  <= '0;
                    fast_sum_reg <= '0;
                    pass_reg     <= 1'b0;
                end else begin
                    index_reg    <= index_reg + 1'b1;
                    base_sum_reg <= base_add;
                    sig_sum_reg  <= sig_add;
                    fast_sum_reg <= fast_add;
                end
            end
            if (state_reg == gbci_pkg::ST_SUB) begin
                pass_reg <= 1'b1;
            end
            if (state_reg == gbci_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last) begin
            base_hold_reg <= base_add;
            sig_hold_reg  <= sig_add;
            fast_hold_reg <= fast_add;
            slow_res_reg  <= '0;
            fast_res_reg  <= '0;
            priority if (bad_base) begin
                status_reg <= gbci_pkg::STATUS_BAD_BASE;
            end else if (bad_sig || bad_fast) begin
                status_reg <= gbci_pkg::STATUS_BAD_SIG;
            end else begin
                status_reg <= gbci_pkg::STATUS_OK;
            end
        end
        if (state_reg == gbci_pkg::ST_SUB) begin
            if (pass_reg) begin
                fast_res_reg <= diff[OUT_W-1:0];
            end else begin
                slow_res_reg <= diff[OUT_W-1:0];
            end
        end
        if (state_reg == gbci_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) begin
            out_slow_reg   <= slow_res_reg;
            out_fast_reg   <= fast_res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{gbci_pkg::M_PAD_W{1'b0}}, out_fast_reg, out_slow_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/gbci_div.sv =====
module gbci_div #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DVS_W-1:0]   divisor,
    output gbci_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] trial;
    logic           ge;

    // One restoring step per cycle while busy: one quotient bit enters at the bottom.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = shifted >= (DVS_W + 1)'(divisor);
    assign trial   = shifted - (DVS_W + 1)'(divisor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/gbci_checker.sv =====
module gbci_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gbci_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic [gbci_pkg::STATUS_W-1:0]       m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != gbci_pkg::STATUS_OK) |-> (m_tdata == '0))
        else $error("bad gate result carries nonzero integrals");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == gbci_pkg::STATUS_OK) || (m_tuser == gbci_pkg::STATUS_BAD_BASE)
                     || (m_tuser == gbci_pkg::STATUS_BAD_SIG))
        else $error("undefined status code");

    a_busy_before_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while samples were being taken");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind gated_baseline_charge_integrator gbci_checker u_gbci_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
